### src/ipv4cb_pkg.sv
// Shared types and constants for the classful IPv4 frame filter.
package ipv4cb_pkg;

	localparam int HOLD_LEN = 30;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 32;

	localparam logic [POS_W-1:0] ETYPE_HI_POS  = 5'd12;
	localparam logic [POS_W-1:0] ETYPE_LO_POS  = 5'd13;
	localparam logic [POS_W-1:0] SRC_OCTET_POS = 5'd26;
	localparam logic [POS_W-1:0] CHECK_POS     = 5'd30;

	localparam logic [15:0] ETYPE_RST    = 16'h0800;
	localparam logic [7:0]  OCTET_LO_RST = 8'd128;
	localparam logic [7:0]  OCTET_HI_RST = 8'd191;

	// Register index codes on the configuration port
	localparam logic [1:0] REG_ETYPE    = 2'd0;
	localparam logic [1:0] REG_OCTET_LO = 2'd1;
	localparam logic [1:0] REG_OCTET_HI = 2'd2;

	typedef enum logic [1:0] {
		V_COLLECT,
		V_PASS,
		V_DROP
	} verdict_t;

	typedef enum logic {
		B_IDLE,
		B_REPLAY
	} back_state_t;

	typedef struct packed {
		logic [15:0] etype;
		logic [7:0]  octet_low;
		logic [7:0]  octet_high;
	} cfg_t;

	typedef struct packed {
		logic       replay;
		logic       last;
		logic [7:0] data;
	} q_entry_t;

	typedef struct packed {
		logic             release_hold;
		logic [POS_W-1:0] idx;
	} hold_req_t;

endpackage

### src/ipv4_class_b_frame_filter_top.sv
// Top level of the classful IPv4 frame filter: config registers and part wiring.
//
// Path: a passing frame's offset-30 byte is pushed into the queue, then the back part
// loads held byte zero into the output register; later bytes follow one per cycle when
// the output is not stalled. Throughput: one byte per cycle for header bytes, dropped
// bytes and pass-through while the queue has room; the next frame's header bytes wait
// for a passed frame's header replay (the back part reads the single header store).
// Reset: arst_n clears all control state and sets the registers to ethertype 0x0800,
// octet range 128..191; the header store has no reset and needs no clearing pass.
module ipv4_class_b_frame_filter_top
	import ipv4cb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] frames_passed
	output logic        m_tlast    // out_last
);

	cfg_t               cfg_q;
	logic               cfg_wr;
	logic [1:0]         reg_idx;
	logic               q_push;
	q_entry_t           q_entry;
	logic               q_full;
	logic               q_pop;
	q_entry_t           q_head;
	logic               q_empty;
	hold_req_t          hold_req;
	logic [7:0]         hold_data;
	logic [7:0]         out_byte;
	logic [COUNT_W-1:0] frames_passed;

	// Registers sit at byte address 4*i; the word index is all that decodes
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.etype      <= ETYPE_RST;
			cfg_q.octet_low  <= OCTET_LO_RST;
			cfg_q.octet_high <= OCTET_HI_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ETYPE:    cfg_q.etype      <= pwdata[15:0];
				REG_OCTET_LO: cfg_q.octet_low  <= pwdata[7:0];
				REG_OCTET_HI: cfg_q.octet_high <= pwdata[7:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ETYPE:    prdata = {16'd0, cfg_q.etype};
			REG_OCTET_LO: prdata = {24'd0, cfg_q.octet_low};
			REG_OCTET_HI: prdata = {24'd0, cfg_q.octet_high};
			default:      prdata = '0;
		endcase
	end

	// Front: hold the header, decide at offset 30, queue what must go out
	ipv4cb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_push    (q_push),
		.q_entry   (q_entry),
		.q_full    (q_full),
		.hold_req  (hold_req),
		.hold_data (hold_data)
	);

	// Queue decouples classification from the replay and output stall
	ipv4cb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	// Back: replay the held header on a pass, then stream the frame's tail
	ipv4cb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.hold_req      (hold_req),
		.hold_data     (hold_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.out_byte      (out_byte),
		.out_last      (m_tlast),
		.frames_passed (frames_passed)
	);

	assign m_tdata = {frames_passed, out_byte};

endmodule

### src/ipv4cb_queue.sv
// Short FIFO of classified bytes between the front and back parts.
module ipv4cb_queue
	import ipv4cb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");

endmodule

### src/ipv4cb_front.sv
// Front part: collect the header, classify the frame, queue bytes to send.
module ipv4cb_front
	import ipv4cb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic [7:0] s_tdata,
	input  logic      s_tlast,
	output logic      q_push,
	output q_entry_t  q_entry,
	input  logic      q_full,
	input  hold_req_t hold_req,
	output logic [7:0] hold_data
);

	verdict_t         verdict_q, verdict_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             busy_q, busy_d;
	logic             hold_we;
	logic [7:0]       hold_q [HOLD_LEN];
	logic [7:0]       eth_hi_q, eth_lo_q, src_q;
	logic             accept;
	logic             frame_ok;

	function automatic logic in_range(input logic [7:0] v, input cfg_t c);
		in_range = (v >= c.octet_low) && (v <= c.octet_high);
	endfunction

	// Header store is owned by the back part while a replay is pending
	assign s_tready = !q_full && !(verdict_q == V_COLLECT && busy_q);
	assign accept   = s_tvalid && s_tready;
	assign frame_ok = ({eth_hi_q, eth_lo_q} == cfg.etype) && in_range(src_q, cfg)
		&& in_range(s_tdata, cfg);
	assign hold_data = (hold_req.idx < POS_W'(HOLD_LEN)) ? hold_q[hold_req.idx] : '0;

	always_comb begin
		verdict_d      = verdict_q;
		pos_d          = pos_q;
		busy_d         = busy_q;
		hold_we        = 1'b0;
		q_push         = 1'b0;
		q_entry.replay = 1'b0;
		q_entry.last   = s_tlast;
		q_entry.data   = s_tdata;
		if (hold_req.release_hold) begin
			busy_d = 1'b0;
		end
		if (accept) begin
			unique case (verdict_q)
				V_COLLECT: begin
					if (pos_q != CHECK_POS) begin
						hold_we = 1'b1;
						pos_d   = s_tlast ? '0 : POS_W'(pos_q + 1'b1);
					end else begin
						pos_d = '0;
						if (frame_ok) begin
							q_push         = 1'b1;
							q_entry.replay = 1'b1;
							busy_d         = 1'b1;
							verdict_d      = s_tlast ? V_COLLECT : V_PASS;
						end else begin
							verdict_d = s_tlast ? V_COLLECT : V_DROP;
						end
					end
				end
				V_PASS: begin
					q_push = 1'b1;
					if (s_tlast) begin
						verdict_d = V_COLLECT;
					end
				end
				V_DROP: begin
					if (s_tlast) begin
						verdict_d = V_COLLECT;
					end
				end
				default: begin
					verdict_d = V_COLLECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q <= V_COLLECT;
			pos_q     <= '0;
			busy_q    <= 1'b0;
		end else begin
			verdict_q <= verdict_d;
			pos_q     <= pos_d;
			busy_q    <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_we) begin
			hold_q[pos_q] <= s_tdata;
			if (pos_q == ETYPE_HI_POS) begin
				eth_hi_q <= s_tdata;
			end
			if (pos_q == ETYPE_LO_POS) begin
				eth_lo_q <= s_tdata;
			end
			if (pos_q == SRC_OCTET_POS) begin
				src_q <= s_tdata;
			end
		end
	end

	a_release_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hold_req.release_hold |-> busy_q)
		else $error("header released with no replay pending");

endmodule

### src/ipv4cb_back.sv
// Back part: replay held headers, pass bytes through, drive the output register.
module ipv4cb_back
	import ipv4cb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  q_entry_t           q_head,
	output logic               q_pop,
	output hold_req_t          hold_req,
	input  logic [7:0]         hold_data,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         out_byte,
	output logic               out_last,
	output logic [COUNT_W-1:0] frames_passed
);

	back_state_t        state_q, state_d;
	logic [POS_W-1:0]   idx_q, idx_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               slot_free;
	logic               load;
	logic [7:0]         load_byte;
	logic               load_last;
	logic               release_hold;

	assign slot_free     = !out_valid_q || m_tready;
	assign hold_req      = '{release_hold: release_hold, idx: idx_q};
	assign m_tvalid      = out_valid_q;
	assign out_byte      = out_byte_q;
	assign out_last      = out_last_q;
	assign frames_passed = out_count_q;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		count_d      = count_q;
		q_pop        = 1'b0;
		load         = 1'b0;
		load_byte    = hold_data;
		load_last    = 1'b0;
		release_hold = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty && slot_free) begin
					load = 1'b1;
					if (q_head.replay) begin
						// Open a passed frame: count it and send held byte zero
						count_d = COUNT_W'(count_q + 1'b1);
						idx_d   = POS_W'(idx_q + 1'b1);
						state_d = B_REPLAY;
					end else begin
						load_byte = q_head.data;
						load_last = q_head.last;
						q_pop     = 1'b1;
					end
				end
			end
			B_REPLAY: begin
				if (slot_free) begin
					load = 1'b1;
					if (idx_q != CHECK_POS) begin
						idx_d = POS_W'(idx_q + 1'b1);
					end else begin
						load_byte    = q_head.data;
						load_last    = q_head.last;
						q_pop        = 1'b1;
						release_hold = 1'b1;
						idx_d        = '0;
						state_d      = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= load_byte;
			out_last_q  <= load_last;
			out_count_q <= count_d;
		end
	end

	a_replay_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_REPLAY) |-> (!q_empty && q_head.replay))
		else $error("replay running without its queue entry");

	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> (idx_q == '0))
		else $error("replay index not parked while idle");

endmodule

### sim/tb_ipv4_class_b_frame_filter_top.sv
// Self-checking testbench for the classful IPv4 frame filter: byte streams against a predictor.
`timescale 1ns / 1ps

module tb_ipv4_class_b_frame_filter_top
	import ipv4cb_pkg::*;
;

	// Index with no register behind it; writes there must change nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// One output transaction as the filter should produce it
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] count;
	} beat_t;

	// One directed frame: the settings to use, the header fields, the length in
	// bytes and whether the frame should come out
	typedef struct packed {
		logic [15:0] cfg_etype;
		logic [7:0]  cfg_lo;
		logic [7:0]  cfg_hi;
		logic [15:0] etype;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [7:0]  len;
		logic        pass;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] in_byte
	logic        s_tlast = 1'b0; // in_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [7:0] out_byte, [39:8] frames_passed
	logic        m_tlast;        // out_last

	ipv4_class_b_frame_filter_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// Shadow of the filter: settings, header store, frame position and verdict
	logic [15:0]      cfg_etype = ETYPE_RST;
	logic [7:0]       cfg_lo = OCTET_LO_RST;
	logic [7:0]       cfg_hi = OCTET_HI_RST;
	logic [7:0]       hold_bytes [HOLD_LEN];
	logic [POS_W-1:0] hold_pos = '0;
	verdict_t         verdict = V_COLLECT;
	logic [31:0]      frames_ok = '0;

	beat_t pending_bytes [$];   // bytes still owed by the filter, oldest first
	beat_t want;
	int    errors = 0;
	int    frames_seen = 0;     // frames closed by an output tlast
	int    sink_stall = 0;
	bit    sink_burst = 1'b0;
	bit    src_burst = 1'b0;

	function automatic bit in_class(input logic [7:0] octet);
		return octet >= cfg_lo && octet <= cfg_hi;
	endfunction

	// Append one owed byte at the tail of the expected stream
	function automatic void owe_byte(input beat_t e);
		pending_bytes = {pending_bytes, e};
	endfunction

	// Advance the shadow by one accepted input byte and queue what it releases
	function automatic void filter_byte(input logic [7:0] b, input logic l);
		logic [15:0] et;
		case (verdict)
			V_COLLECT: begin
				if (hold_pos < HOLD_LEN) begin
					hold_bytes[hold_pos] = b;
					hold_pos = l ? '0 : hold_pos + 1'b1;
				end else begin
					et = {hold_bytes[ETYPE_HI_POS], hold_bytes[ETYPE_LO_POS]};
					if (et == cfg_etype && in_class(hold_bytes[SRC_OCTET_POS])
							&& in_class(b)) begin
						frames_ok = frames_ok + 1;
						for (int i = 0; i < HOLD_LEN; i++)
							owe_byte(beat_t'{hold_bytes[i], 1'b0, frames_ok});
						owe_byte(beat_t'{b, l, frames_ok});
						if (l)
							hold_pos = '0;
						else
							verdict = V_PASS;
					end else if (l) begin
						hold_pos = '0;
					end else begin
						verdict = V_DROP;
					end
				end
			end
			V_PASS: begin
				owe_byte(beat_t'{b, l, frames_ok});
				if (l) begin
					verdict = V_COLLECT;
					hold_pos = '0;
				end
			end
			default: begin
				if (l) begin
					verdict = V_COLLECT;
					hold_pos = '0;
				end
			end
		endcase
	endfunction

	// Output side: check every transaction against the oldest owed byte
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected output, expected nothing, got byte %h last %b count %0d",
					$time, m_tdata[7:0], m_tlast, m_tdata[39:8]);
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata[7:0] !== want.data) begin
					errors++;
					$display("%0t: out_byte expected %h got %h", $time, want.data, m_tdata[7:0]);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: out_last expected %b got %b", $time, want.last, m_tlast);
				end
				if (m_tdata[39:8] !== want.count) begin
					errors++;
					$display("%0t: frames_passed expected %0d got %0d",
						$time, want.count, m_tdata[39:8]);
				end
			end
			if (m_tlast)
				frames_seen++;
			// flip between stalling and full rate now and then
			if ($urandom_range(0, 39) == 0)
				sink_burst = ~sink_burst;
			sink_stall = sink_burst ? 0 : $urandom_range(0, 7);
		end
	end

	// Hold tready low for the drawn stall, then raise it until the next transaction
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			m_tready <= 1'b0;
			sink_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one byte after a random gap and wait for the transaction
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		filter_byte(b, l);
	endtask

	// Build a frame of random bytes with the checked fields put in place
	task automatic send_frame(input logic [15:0] et, input logic [7:0] src,
			input logic [7:0] dst, input int len);
		logic [7:0] b;
		src_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i == ETYPE_HI_POS) b = et[15:8];
			if (i == ETYPE_LO_POS) b = et[7:0];
			if (i == SRC_OCTET_POS) b = src;
			if (i == CHECK_POS) b = dst;
			send_byte(b, i == len - 1);
		end
	endtask

	// Stop sending and wait out every owed byte, then let the replay tail settle
	task automatic drain_outputs();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ETYPE:    cfg_etype = val[15:0];
			REG_OCTET_LO: cfg_lo = val[7:0];
			REG_OCTET_HI: cfg_hi = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Settings change only with the filter idle
	task automatic apply_config(input logic [15:0] et, input logic [7:0] lo,
			input logic [7:0] hi);
		drain_outputs();
		write_reg(REG_ETYPE, {16'h0, et});
		write_reg(REG_OCTET_LO, {24'h0, lo});
		write_reg(REG_OCTET_HI, {24'h0, hi});
	endtask

	// Directed frames: boundaries of the class range, wrong ethertype, short frames,
	// a frame ending right at the check byte, range extremes and an empty range
	plan_row_t plan [11] = '{
		'{16'h0800, 8'd128, 8'd191, 16'h0800, 8'd128, 8'd191, 8'd31, 1'b1},
		'{16'h0800, 8'd128, 8'd191, 16'h0800, 8'd127, 8'd150, 8'd31, 1'b0},
		'{16'h0800, 8'd128, 8'd191, 16'h0800, 8'd150, 8'd192, 8'd31, 1'b0},
		'{16'h0800, 8'd128, 8'd191, 16'h0801, 8'd150, 8'd150, 8'd31, 1'b0},
		'{16'h0800, 8'd128, 8'd191, 16'h0800, 8'd150, 8'd150, 8'd1,  1'b0},
		'{16'h0800, 8'd128, 8'd191, 16'h0800, 8'd150, 8'd150, 8'd30, 1'b0},
		'{16'h0800, 8'd128, 8'd191, 16'h0800, 8'd191, 8'd128, 8'd40, 1'b1},
		'{16'hFFFF, 8'd0,   8'd255, 16'hFFFF, 8'd0,   8'd255, 8'd32, 1'b1},
		'{16'h0000, 8'd0,   8'd0,   16'h0000, 8'd0,   8'd0,   8'd31, 1'b1},
		'{16'h0000, 8'd255, 8'd255, 16'h0000, 8'd255, 8'd255, 8'd32, 1'b1},
		'{16'h0000, 8'd200, 8'd100, 16'h0000, 8'd150, 8'd150, 8'd31, 1'b0}
	};

	initial begin
		int seen_before;
		int sent_bytes;
		int len;
		int mode;
		logic [15:0] et;
		logic [7:0] lo, hi, src, dst;

		// Assert reset once, release it on a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: every row goes through the predictor, and the typed
		// pass column is checked against the frames the filter actually closed
		sent_bytes = 0;
		foreach (plan[r]) begin
			if (plan[r].cfg_etype != cfg_etype || plan[r].cfg_lo != cfg_lo
					|| plan[r].cfg_hi != cfg_hi)
				apply_config(plan[r].cfg_etype, plan[r].cfg_lo, plan[r].cfg_hi);
			seen_before = frames_seen;
			send_frame(plan[r].etype, plan[r].src, plan[r].dst, plan[r].len);
			sent_bytes += plan[r].len;
			drain_outputs();
			if (frames_seen - seen_before != plan[r].pass) begin
				errors++;
				$display("%0t: frame %0d passed frames expected %0d got %0d",
					$time, r, plan[r].pass, frames_seen - seen_before);
			end
		end

		// Write to the unmapped index; the random part then writes all three registers anew
		write_reg(REG_UNUSED, $urandom);

		// Random part: phases of a few frames per setting, mostly well-formed frames,
		// until the whole run has sent its byte budget
		while (sent_bytes < 370) begin
			mode = $urandom_range(0, 4);
			et = ($urandom_range(0, 3) == 0) ? 16'h0800 : 16'($urandom);
			lo = 8'($urandom_range(0, 255));
			hi = 8'($urandom_range(lo, 255));
			if (mode == 0) begin
				lo = 8'd0;
				hi = 8'd255;
			end else if (mode == 1) begin
				lo = 8'($urandom_range(1, 255));
				hi = 8'($urandom_range(0, lo - 1));
			end
			apply_config(et, lo, hi);
			for (int f = 0; f < 4 && sent_bytes < 370; f++) begin
				et = cfg_etype;
				src = (cfg_lo <= cfg_hi) ? 8'($urandom_range(cfg_lo, cfg_hi)) : 8'($urandom);
				dst = (cfg_lo <= cfg_hi) ? 8'($urandom_range(cfg_lo, cfg_hi)) : 8'($urandom);
				// break about one frame in five in one of its checked fields
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 2))
						0: et = et ^ (16'h1 << $urandom_range(0, 15));
						1: src = 8'($urandom);
						default: dst = 8'($urandom);
					endcase
				end
				case ($urandom_range(0, 9))
					0:       len = $urandom_range(1, 30);
					1:       len = $urandom_range(49, 64);
					default: len = $urandom_range(31, 48);
				endcase
				send_frame(et, src, dst, len);
				sent_bytes += len;
			end
		end

		// Let everything owed come out, then report
		drain_outputs();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_ipv4_class_b_frame_filter_top OK");
		else
			$display("tb_ipv4_class_b_frame_filter_top NOT OK");
		$finish;
	end

	// Watchdog well past the slowest correct run
	initial begin
		#2_000_000;
		$display("tb_ipv4_class_b_frame_filter_top NOT OK");
		$finish;
	end

endmodule
